### hw/rtl/xts_pkg.sv
// xts_pkg: shared widths, matrix coefficients, curve constants and the
// elaboration-time builders for the gamma table and the linear-segment table
// no dependencies
package xts_pkg;

   localparam int DEFAULT_GAMMA_ADDR_BITS = 10;

   localparam int NUM_CH = 3;
   localparam int XYZ_W  = 16;
   localparam int RGB_W  = 16;

   // matrix datapath
   localparam int COEF_W = 17;
   localparam int PROD_W = COEF_W + XYZ_W + 1;
   localparam int ACC_W  = PROD_W + 2;

   localparam logic signed [COEF_W-1:0] XYZ_TO_RGB [NUM_CH][NUM_CH] = '{
      '{ 17'sd53092, -17'sd25184, -17'sd8168 },
      '{-17'sd15880,  17'sd30737,  17'sd681  },
      '{ 17'sd912,   -17'sd3343,   17'sd17322}
   };

   // linear channel, unsigned q.16 with room for 1.0
   localparam int LIN_SHIFT     = 13;
   localparam int LIN_FRAC_BITS = 16;
   localparam int LIN_W         = LIN_FRAC_BITS + 1;

   localparam logic signed [ACC_W-1:0] ACC_ONE   = ACC_W'(64'd1 << 29);
   localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(64'd1 << (LIN_SHIFT - 1));
   localparam logic [LIN_W-1:0]        LIN_ONE   = LIN_W'(64'd1 << LIN_FRAC_BITS);
   localparam logic [LIN_W-1:0]        LIN_THRESH = LIN_W'(205);

   // linear segment: out = (lin * 12.92) rounded
   localparam int LIN_SEG_AW    = 8;
   localparam int LIN_SEG_DEPTH = 1 << LIN_SEG_AW;
   localparam int LIN_SEG_W     = 12;
   localparam int LIN_SLOPE_NUM = 1292;
   localparam int LIN_SLOPE_DEN = 100;

   typedef logic [LIN_SEG_W-1:0] lin_seg_table_type [LIN_SEG_DEPTH];

   // gamma table and encode
   localparam int GAMMA_W     = 17;
   localparam int ENC_SCALE_W = 17;
   localparam int ENC_PROD_W  = GAMMA_W + ENC_SCALE_W;
   localparam int ENC_SHIFT   = 16;
   localparam int ENC_E_W     = 17;

   localparam logic [ENC_SCALE_W-1:0] ENC_SCALE  = ENC_SCALE_W'(69140);
   localparam logic [ENC_PROD_W-1:0]  ENC_ROUND  = ENC_PROD_W'(32768);
   localparam logic [ENC_E_W-1:0]     ENC_OFFSET = ENC_E_W'(3604);
   localparam logic [ENC_E_W-1:0]     RGB_MAX    = ENC_E_W'(65535);

   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] probe;
      rem   = value;
      res   = '0;
      probe = 64'd1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 64'd0) begin
         if (rem >= res + probe) begin
            rem = rem - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] icbrt64(input logic [63:0] value);
      logic [63:0] root;
      logic [63:0] cand;
      root = '0;
      for (int b = 20; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand * cand <= value) root = cand;
      end
      return root;
   endfunction

   // x^(5/12) at x = addr / 2^addr_bits, q.16, as x^(1/4) * x^(1/6)
   function automatic logic [GAMMA_W-1:0] gamma_entry(input int unsigned addr,
                                                      input int addr_bits);
      logic [63:0] v;
      logic [63:0] w;
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] prod;
      v    = 64'(addr) << (30 - addr_bits);
      q    = isqrt64(isqrt64(v << 30) << 30);
      w    = 64'(addr) << (20 - addr_bits);
      r    = isqrt64(icbrt64(w << 40) << 20);
      prod = q * r + (64'd1 << 33);
      return GAMMA_W'(prod >> 34);
   endfunction

   function automatic lin_seg_table_type build_lin_seg_table();
      lin_seg_table_type t;
      for (int n = 0; n < LIN_SEG_DEPTH; n++) begin
         t[n] = LIN_SEG_W'((n * LIN_SLOPE_NUM + LIN_SLOPE_DEN / 2) / LIN_SLOPE_DEN);
      end
      return t;
   endfunction

endpackage

### hw/rtl/xts_req_if.sv
// xts_req_if: valid/ready channel carrying one xyz word
// depends on xts_pkg
interface xts_req_if import xts_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [XYZ_W-1:0] x_in;
   logic [XYZ_W-1:0] y_in;
   logic [XYZ_W-1:0] z_in;

   modport source (output valid, x_in, y_in, z_in, input ready);
   modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

### hw/rtl/xts_rsp_if.sv
// xts_rsp_if: valid/ready channel carrying one srgb word and the clip flag
// depends on xts_pkg
interface xts_rsp_if import xts_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RGB_W-1:0] red_out;
   logic [RGB_W-1:0] green_out;
   logic [RGB_W-1:0] blue_out;
   logic             clipped;

   modport source (output valid, red_out, green_out, blue_out, clipped, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, clipped, output ready);
endinterface

### hw/rtl/xyz_to_srgb_converter_top.sv
// xyz_to_srgb_converter_top: cie xyz (d65) to gamma-encoded srgb pipeline
// depends on xts_pkg, xts_req_if, xts_rsp_if, xts_gamma_rom
//
// Converts one XYZ word (unsigned Q1.15 per component) into one sRGB word
// (unsigned Q0.16 per channel) plus a clipped flag. Throughput is one word per
// clock while rsp_chan.ready holds high. The first of six register stages loads
// at the accepting edge, and the word moves on through the later stages to the
// result register, where it waits for rsp_chan.ready. The stages are: matrix
// products, sums and saturation to [0,1], gamma table read, interpolation, 1.055
// scaling, offset and final saturation.
// Stalls only fill bubbles: req_chan.ready stays high while any stage is
// empty, so a result waiting in the output register does not block new input
// until the pipeline is full. The gamma table is a constant of
// 2^GAMMA_TABLE_ADDR_BITS + 1 entries, built at elaboration, so there is no
// start-up fill or clearing time after reset.
module xyz_to_srgb_converter_top import xts_pkg::*; #(
   parameter int GAMMA_TABLE_ADDR_BITS = DEFAULT_GAMMA_ADDR_BITS
) (
   input  logic         clock,
   input  logic         reset,
   xts_req_if.sink      req_chan,
   xts_rsp_if.source    rsp_chan
);

   // stage numbering
   localparam int NUM_STAGES = 6;
   localparam int S_MUL      = 0;
   localparam int S_SUM      = 1;
   localparam int S_ROM      = 2;
   localparam int S_INTERP   = 3;
   localparam int S_SCALE    = 4;
   localparam int S_OUT      = 5;

   // table position and fraction taken from the linear value
   localparam int FRAC_BITS = LIN_FRAC_BITS - GAMMA_TABLE_ADDR_BITS;
   localparam int INTERP_W  = GAMMA_W + FRAC_BITS + 1;
   localparam logic [INTERP_W-1:0] INTERP_HALF = INTERP_W'(64'd1 << (FRAC_BITS - 1));

   localparam lin_seg_table_type LIN_SEG_TABLE = build_lin_seg_table();

   // pipeline control: each stage moves when it is empty or the next one moves
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] adv;

   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[S_MUL]) valid_ff[S_MUL] <= req_chan.valid;
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (adv[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign req_chan.ready = adv[S_MUL];

   // inputs as positive signed operands
   logic signed [XYZ_W:0] xyz_s [NUM_CH];

   assign xyz_s[0] = {1'b0, req_chan.x_in};
   assign xyz_s[1] = {1'b0, req_chan.y_in};
   assign xyz_s[2] = {1'b0, req_chan.z_in};

   // per-channel stage registers
   logic signed [PROD_W-1:0]  s1_prod_ff [NUM_CH][NUM_CH];
   logic [LIN_W-1:0]          s2_lin_ff  [NUM_CH];
   logic [NUM_CH-1:0]         s2_clip_ch;
   logic                      s2_clip_ff;
   logic [GAMMA_W-1:0]        s3_lo      [NUM_CH];
   logic [GAMMA_W-1:0]        s3_hi      [NUM_CH];
   logic [FRAC_BITS-1:0]      s3_frac_ff [NUM_CH];
   logic [NUM_CH-1:0]         s3_is_lin_ff;
   logic [LIN_SEG_W-1:0]      s3_seg_ff  [NUM_CH];
   logic                      s3_clip_ff;
   logic [GAMMA_W-1:0]        s4_p_ff    [NUM_CH];
   logic [NUM_CH-1:0]         s4_is_lin_ff;
   logic [LIN_SEG_W-1:0]      s4_seg_ff  [NUM_CH];
   logic                      s4_clip_ff;
   logic [ENC_E_W-1:0]        s5_e_ff    [NUM_CH];
   logic [NUM_CH-1:0]         s5_is_lin_ff;
   logic [LIN_SEG_W-1:0]      s5_seg_ff  [NUM_CH];
   logic                      s5_clip_ff;
   logic [RGB_W-1:0]          s6_rgb_ff  [NUM_CH];
   logic                      s6_clip_ff;

   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
      logic signed [PROD_W-1:0] s1_prod_in [NUM_CH];
      logic signed [ACC_W-1:0]  acc;
      logic signed [ACC_W-1:0]  acc_rnd;
      logic [LIN_W-1:0]         s2_lin_in;
      logic [GAMMA_W-1:0]       step_diff;
      logic [INTERP_W-1:0]      step_scaled;
      logic [GAMMA_W:0]         p_sum;
      logic [ENC_PROD_W-1:0]    enc_prod;
      logic [ENC_E_W-1:0]       curve_val;
      logic [RGB_W-1:0]         s6_rgb_in;

      // stage 1: three products per channel
      always_comb begin
         for (int k = 0; k < NUM_CH; k++) begin
            s1_prod_in[k] = XYZ_TO_RGB[ch][k] * xyz_s[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[S_MUL]) begin
            for (int k = 0; k < NUM_CH; k++) s1_prod_ff[ch][k] <= s1_prod_in[k];
         end
      end

      // stage 2: sum, saturate to [0,1], round to q.16
      always_comb begin
         acc = {{(ACC_W - PROD_W){s1_prod_ff[ch][0][PROD_W-1]}}, s1_prod_ff[ch][0]}
             + {{(ACC_W - PROD_W){s1_prod_ff[ch][1][PROD_W-1]}}, s1_prod_ff[ch][1]}
             + {{(ACC_W - PROD_W){s1_prod_ff[ch][2][PROD_W-1]}}, s1_prod_ff[ch][2]};
         acc_rnd        = acc + ACC_ROUND;
         s2_clip_ch[ch] = 1'b0;
         if (acc[ACC_W-1]) begin
            s2_lin_in      = '0;
            s2_clip_ch[ch] = 1'b1;
         end else if (acc > ACC_ONE) begin
            s2_lin_in      = LIN_ONE;
            s2_clip_ch[ch] = 1'b1;
         end else begin
            s2_lin_in = acc_rnd[LIN_SHIFT +: LIN_W];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[S_SUM]) s2_lin_ff[ch] <= s2_lin_in;
      end

      // stage 3: table neighbors, linear-segment value
      xts_gamma_rom #(
         .ADDR_BITS (GAMMA_TABLE_ADDR_BITS)
      ) u_rom (
         .clock  (clock),
         .load   (adv[S_ROM]),
         .index  (s2_lin_ff[ch][LIN_W-1:FRAC_BITS]),
         .rom_lo (s3_lo[ch]),
         .rom_hi (s3_hi[ch])
      );

      always_ff @(posedge clock) begin
         if (adv[S_ROM]) begin
            s3_frac_ff[ch]   <= s2_lin_ff[ch][FRAC_BITS-1:0];
            s3_is_lin_ff[ch] <= (s2_lin_ff[ch] <= LIN_THRESH);
            s3_seg_ff[ch]    <= LIN_SEG_TABLE[s2_lin_ff[ch][LIN_SEG_AW-1:0]];
         end
      end

      // stage 4: linear interpolation between neighbors
      always_comb begin
         step_diff   = s3_hi[ch] - s3_lo[ch];
         step_scaled = INTERP_W'(step_diff) * INTERP_W'(s3_frac_ff[ch]) + INTERP_HALF;
         p_sum       = {1'b0, s3_lo[ch]} + step_scaled[FRAC_BITS +: GAMMA_W + 1];
      end

      always_ff @(posedge clock) begin
         if (adv[S_INTERP]) begin
            s4_p_ff[ch]      <= p_sum[GAMMA_W-1:0];
            s4_is_lin_ff[ch] <= s3_is_lin_ff[ch];
            s4_seg_ff[ch]    <= s3_seg_ff[ch];
         end
      end

      // stage 5: scale by 1.055 with rounding
      always_comb begin
         enc_prod = ENC_PROD_W'(s4_p_ff[ch]) * ENC_PROD_W'(ENC_SCALE) + ENC_ROUND;
      end

      always_ff @(posedge clock) begin
         if (adv[S_SCALE]) begin
            s5_e_ff[ch]      <= enc_prod[ENC_SHIFT +: ENC_E_W];
            s5_is_lin_ff[ch] <= s4_is_lin_ff[ch];
            s5_seg_ff[ch]    <= s4_seg_ff[ch];
         end
      end

      // stage 6: subtract 0.055, clamp to the q0.16 range, pick the segment
      always_comb begin
         curve_val = s5_e_ff[ch] - ENC_OFFSET;
         if (s5_is_lin_ff[ch]) begin
            s6_rgb_in = RGB_W'(s5_seg_ff[ch]);
         end else if (s5_e_ff[ch] <= ENC_OFFSET) begin
            s6_rgb_in = '0;
         end else if (curve_val > RGB_MAX) begin
            s6_rgb_in = RGB_MAX[RGB_W-1:0];
         end else begin
            s6_rgb_in = curve_val[RGB_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[S_OUT]) s6_rgb_ff[ch] <= s6_rgb_in;
      end
   end

   // clip flag rides along with the word
   always_ff @(posedge clock) begin
      if (adv[S_SUM])    s2_clip_ff <= |s2_clip_ch;
      if (adv[S_ROM])    s3_clip_ff <= s2_clip_ff;
      if (adv[S_INTERP]) s4_clip_ff <= s3_clip_ff;
      if (adv[S_SCALE])  s5_clip_ff <= s4_clip_ff;
      if (adv[S_OUT])    s6_clip_ff <= s5_clip_ff;
   end

   // result register drives the response channel
   assign rsp_chan.valid     = valid_ff[S_OUT];
   assign rsp_chan.red_out   = s6_rgb_ff[0];
   assign rsp_chan.green_out = s6_rgb_ff[1];
   assign rsp_chan.blue_out  = s6_rgb_ff[2];
   assign rsp_chan.clipped   = s6_clip_ff;

endmodule

### hw/rtl/xts_gamma_rom.sv
// xts_gamma_rom: x^(5/12) table split in even and odd banks, so both
// neighbors of a table position come out in one registered read
// depends on xts_pkg
module xts_gamma_rom import xts_pkg::*; #(
   parameter int ADDR_BITS = DEFAULT_GAMMA_ADDR_BITS
) (
   input  logic               clock,
   input  logic               load,
   input  logic [ADDR_BITS:0] index,
   output logic [GAMMA_W-1:0] rom_lo,
   output logic [GAMMA_W-1:0] rom_hi
);

   localparam int BANK_DEPTH = (1 << (ADDR_BITS - 1)) + 1;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);

   typedef logic [GAMMA_W-1:0] bank_type [BANK_DEPTH];

   // last odd slot repeats the final entry, only read with a zero fraction
   function automatic bank_type build_bank(input int odd);
      bank_type t;
      int       entry;
      for (int k = 0; k < BANK_DEPTH; k++) begin
         entry = 2 * k + odd;
         if (entry > (1 << ADDR_BITS)) entry = 1 << ADDR_BITS;
         t[k] = gamma_entry(unsigned'(entry), ADDR_BITS);
      end
      return t;
   endfunction

   localparam bank_type EVEN_BANK = build_bank(0);
   localparam bank_type ODD_BANK  = build_bank(1);

   logic [ADDR_BITS+1:0] index_inc;
   logic [BANK_AW-1:0]   even_idx;
   logic [BANK_AW-1:0]   odd_idx;
   logic [GAMMA_W-1:0]   even_word;
   logic [GAMMA_W-1:0]   odd_word;
   logic [GAMMA_W-1:0]   lo_in;
   logic [GAMMA_W-1:0]   hi_in;
   logic [GAMMA_W-1:0]   lo_ff;
   logic [GAMMA_W-1:0]   hi_ff;

   always_comb begin
      index_inc = {1'b0, index} + (ADDR_BITS + 2)'(1);
      even_idx  = index_inc[BANK_AW:1];
      odd_idx   = index[BANK_AW:1];
      even_word = EVEN_BANK[even_idx];
      odd_word  = ODD_BANK[odd_idx];
      lo_in     = index[0] ? odd_word  : even_word;
      hi_in     = index[0] ? even_word : odd_word;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign rom_lo = lo_ff;
   assign rom_hi = hi_ff;

endmodule

### tb/sv/tb_top.sv
// tb_top: self-checking bench for the xyz to srgb converter, directed words then random ones
// predicts each word from its own gamma table or a typed row, compares field by field
// depends on xts_pkg, xts_req_if, xts_rsp_if and xyz_to_srgb_converter_top
module tb_top;
   import xts_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int LUT_BITS     = DEFAULT_GAMMA_ADDR_BITS;
   localparam int LUT_TOP      = 1 << LUT_BITS;
   localparam int FRAC_SHIFT   = 16 - LUT_BITS;
   localparam int RANDOM_WORDS = 850;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_WAIT  = 12;
   localparam int HOLD_CYCLES  = 40;
   localparam int HOLD_AT      = 250;
   localparam int CALM_FROM    = 400;
   localparam int CALM_TO      = 550;
   localparam int IDLE_PCT     = 36;

   // d65 xyz to linear srgb, signed q3.14, row per output channel
   localparam longint D65_MATRIX [3][3] = '{
      '{ 53092, -25184, -8168 },
      '{-15880,  30737,   681 },
      '{   912,  -3343, 17322 }
   };
   localparam longint ACC_UNITY  = 64'sd1 << 29;
   localparam int     KNEE_LEVEL = 205;

   typedef struct packed {
      logic [RGB_W-1:0] red;
      logic [RGB_W-1:0] green;
      logic [RGB_W-1:0] blue;
      logic             clipped;
   } srgb_word_type;

   // one xyz word, optionally with a result typed in by hand
   typedef struct packed {
      logic [XYZ_W-1:0] x;
      logic [XYZ_W-1:0] y;
      logic [XYZ_W-1:0] z;
      logic             typed;
      srgb_word_type    want;
   } stim_row_type;

   localparam srgb_word_type NO_WORD = '0;
   localparam int DIRECTED_ROWS = 20;

   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // black: zero accumulators, zero output, no clip
      '{16'd0,     16'd0,     16'd0,     1'b1, '{16'd0, 16'd0, 16'd0, 1'b0}},
      // all components at max: every channel over unity, curve saturates
      '{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}},
      '{16'hFFFF,  16'd0,     16'd0,     1'b0, NO_WORD},
      // y alone at max: red and blue go negative, green over unity
      '{16'd0,     16'hFFFF,  16'd0,     1'b1, '{16'd0, 16'hFFFF, 16'd0, 1'b1}},
      '{16'd0,     16'd0,     16'hFFFF,  1'b0, NO_WORD},
      // d65 white and half white
      '{16'd31146, 16'd32768, 16'd35685, 1'b0, NO_WORD},
      '{16'd15573, 16'd16384, 16'd17842, 1'b0, NO_WORD},
      // greys around the knee between linear segment and power curve
      '{16'd95,    16'd100,   16'd109,   1'b0, NO_WORD},
      '{16'd97,    16'd102,   16'd111,   1'b0, NO_WORD},
      '{16'd98,    16'd103,   16'd112,   1'b0, NO_WORD},
      '{16'd99,    16'd104,   16'd113,   1'b0, NO_WORD},
      '{16'd101,   16'd106,   16'd115,   1'b0, NO_WORD},
      // alternating bit patterns
      '{16'hAAAA,  16'h5555,  16'hAAAA,  1'b0, NO_WORD},
      '{16'h5555,  16'hAAAA,  16'h5555,  1'b0, NO_WORD},
      // tiniest nonzero inputs
      '{16'd1,     16'd0,     16'd0,     1'b0, NO_WORD},
      '{16'd1,     16'd1,     16'd1,     1'b0, NO_WORD},
      '{16'd0,     16'h8000,  16'd0,     1'b0, NO_WORD},
      // slightly brighter than white: clips high on all channels
      '{16'd33000, 16'd34700, 16'd37800, 1'b0, NO_WORD},
      '{16'h7FFF,  16'h7FFF,  16'h7FFF,  1'b0, NO_WORD},
      '{16'd3114,  16'd3277,  16'd3569,  1'b0, NO_WORD}
   };

   logic clock;
   logic reset;

   xts_req_if req_chan ();
   xts_rsp_if rsp_chan ();

   xyz_to_srgb_converter_top #(
      .GAMMA_TABLE_ADDR_BITS(LUT_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // x^(5/12) in q.16 at each table address
   longint unsigned curve_lut [LUT_TOP + 1];

   srgb_word_type expected_rgb_q [$];
   int            failures;
   int            words_checked;
   int            idle_cycles;

   // hand-typed expectation of the word currently on the input, set at the falling edge
   logic          pinned_valid;
   srgb_word_type pinned_word;

   always #HALF_PERIOD clock = ~clock;

   // append one expected word at the tail of the queue
   function automatic void add_expected(input srgb_word_type w);
      expected_rgb_q = {expected_rgb_q, w};
   endfunction

   // floor integer root; the top probe bit keeps cand^degree inside 64 bits
   function automatic longint unsigned int_root(input longint unsigned value,
                                                input int degree);
      longint unsigned root;
      longint unsigned cand;
      longint unsigned pw;
      root = 0;
      for (int b = 64 / degree - 1; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         pw = 1;
         for (int k = 0; k < degree; k++) pw = pw * cand;
         if (pw <= value) root = cand;
      end
      return root;
   endfunction

   // matrix, saturation to [0,1], srgb transfer curve on each channel
   function automatic srgb_word_type convert_xyz(input logic [XYZ_W-1:0] x,
                                                 input logic [XYZ_W-1:0] y,
                                                 input logic [XYZ_W-1:0] z);
      longint          acc;
      longint unsigned lin;
      longint unsigned idx;
      longint unsigned frac;
      longint unsigned p;
      longint unsigned e;
      longint          comp [3];
      logic [RGB_W-1:0] chan [3];
      srgb_word_type   res;
      comp[0] = longint'(x);
      comp[1] = longint'(y);
      comp[2] = longint'(z);
      res.clipped = 1'b0;
      for (int ch = 0; ch < 3; ch++) begin
         acc = 0;
         for (int k = 0; k < 3; k++) acc += D65_MATRIX[ch][k] * comp[k];
         if (acc < 0) begin
            res.clipped = 1'b1;
            lin = 0;
         end else if (acc > ACC_UNITY) begin
            res.clipped = 1'b1;
            lin = 65536;
         end else begin
            lin = longint'(acc + 4096) >> 13;
         end
         if (lin <= KNEE_LEVEL) begin
            // slope 12.92, rounded
            e = (lin * 1292 + 50) / 100;
         end else begin
            idx  = lin >> FRAC_SHIFT;
            frac = lin & ((64'd1 << FRAC_SHIFT) - 1);
            if (idx >= LUT_TOP) p = curve_lut[LUT_TOP];
            else p = curve_lut[idx] + (((curve_lut[idx + 1] - curve_lut[idx]) * frac
                     + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT);
            // 1.055 * p - 0.055, floored at zero and saturated below 1.0
            e = (p * 69140 + 32768) >> 16;
            e = (e <= 3604) ? 0 : e - 3604;
            if (e > 65535) e = 65535;
         end
         chan[ch] = e[RGB_W-1:0];
      end
      res.red   = chan[0];
      res.green = chan[1];
      res.blue  = chan[2];
      return res;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
         failures++;
      end
   endfunction

   function automatic logic [XYZ_W-1:0] clamp_component(input int v);
      if (v < 0) return '0;
      if (v > 65535) return '1;
      return XYZ_W'(v);
   endfunction

   // corner values mixed with plain random ones
   function automatic logic [XYZ_W-1:0] corner_value();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return XYZ_W'($urandom);
      endcase
   endfunction

   // after random idle gaps unless no_gaps, drive one word from the falling edge,
   // hold it until accepted, return at the falling edge after acceptance
   task automatic send_word(input stim_row_type row, input bit no_gaps);
      while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.x_in  <= row.x;
      req_chan.y_in  <= row.y;
      req_chan.z_in  <= row.z;
      pinned_valid = row.typed;
      pinned_word  = row.want;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // stimulus: table build, reset, directed rows, then random words
   initial begin : stimulus
      longint unsigned v;
      longint unsigned w;
      longint unsigned q;
      longint unsigned r;
      stim_row_type row;
      int sel;
      int span;
      int yi;
      clock          = 1'b0;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.x_in  = '0;
      req_chan.y_in  = '0;
      req_chan.z_in  = '0;
      pinned_valid   = 1'b0;
      pinned_word    = NO_WORD;
      failures       = 0;
      words_checked  = 0;
      idle_cycles    = 0;

      // x^(1/4) in q.30 times x^(1/6) in q.20, rounded to q.16
      for (int a = 0; a <= LUT_TOP; a++) begin
         v = longint'(a) << (30 - LUT_BITS);
         q = int_root(int_root(v << 30, 2) << 30, 2);
         w = longint'(a) << (20 - LUT_BITS);
         r = int_root(int_root(w << 40, 3) << 20, 2);
         curve_lut[a] = (q * r + (64'd1 << 33)) >> 34;
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int n = 0; n < DIRECTED_ROWS; n++) send_word(DIRECTED[n], 1'b0);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         row  = '0;
         sel  = $urandom_range(99);
         if (sel < 30) begin
            // anything goes, mostly out of gamut
            row.x = XYZ_W'($urandom);
            row.y = XYZ_W'($urandom);
            row.z = XYZ_W'($urandom);
         end else if (sel < 70) begin
            // near the white axis so most channels stay in gamut
            yi    = $urandom_range(33000);
            span  = yi / 16 + 8;
            row.x = clamp_component(yi * 95 / 100 + int'($urandom_range(2 * span)) - span);
            row.y = XYZ_W'(yi);
            row.z = clamp_component(yi * 109 / 100 + int'($urandom_range(2 * span)) - span);
         end else if (sel < 85) begin
            // dark colors around the knee of the curve
            row.x = XYZ_W'($urandom_range(400));
            row.y = XYZ_W'($urandom_range(400));
            row.z = XYZ_W'($urandom_range(400));
         end else begin
            row.x = corner_value();
            row.y = corner_value();
            row.z = corner_value();
         end
         // a stretch with the sender never idling
         send_word(row, n >= CALM_FROM && n < CALM_TO);
      end
      req_chan.valid <= 1'b0;

      wait (expected_rgb_q.size() == 0);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (failures == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // result side: random back-pressure, a calm stretch, and one long hold-off
   initial begin : rsp_drain
      bit held;
      held           = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && words_checked >= HOLD_AT) begin
            // pipeline fills and input ready must drop while we hold
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_chan.ready <= (words_checked >= CALM_FROM && words_checked < CALM_TO)
                              || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // predict on input acceptance, compare on output acceptance
   always @(posedge clock) begin : scoreboard
      srgb_word_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            if (pinned_valid) add_expected(pinned_word);
            else add_expected(convert_xyz(req_chan.x_in, req_chan.y_in, req_chan.z_in));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rgb_q.size() == 0) begin
               $display("%0t unexpected word: red %0d green %0d blue %0d clipped %0d",
                        $time, rsp_chan.red_out, rsp_chan.green_out, rsp_chan.blue_out,
                        rsp_chan.clipped);
               failures++;
            end else begin
               want = expected_rgb_q.pop_front();
               check_field("red_out",   want.red,     rsp_chan.red_out);
               check_field("green_out", want.green,   rsp_chan.green_out);
               check_field("blue_out",  want.blue,    rsp_chan.blue_out);
               check_field("clipped",   want.clipped, rsp_chan.clipped);
            end
            words_checked++;
         end
      end
   end

   // stops a hung run: too long without any word moving on either side
   always @(posedge clock) begin : watchdog
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t timeout, %0d words still expected", $time, expected_rgb_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule
